@@ sv/prts_pkg.sv @@
`default_nettype none
package prts_pkg;
	localparam int MAX_TASKS_D  = 8;
	localparam int NUM_LEVELS_D = 4;
	localparam int NUM_QUEUES_D = 8;
	localparam int TIME_BITS_D  = 32;

	typedef enum logic [2:0] {
		CMD_CREATE   = 3'd0,
		CMD_START    = 3'd1,
		CMD_TICK     = 3'd2,
		CMD_YIELD    = 3'd3,
		CMD_DELAY    = 3'd4,
		CMD_WAIT_NE  = 3'd5,
		CMD_WAIT_NF  = 3'd6,
		CMD_UNUSED   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_READY   = 2'd0,
		ST_RUNNING = 2'd1,
		ST_BLOCKED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		WAIT_NONE     = 2'd0,
		WAIT_NONEMPTY = 2'd1,
		WAIT_NONFULL  = 2'd2
	} wait_t;

	typedef enum logic [2:0] {
		S_IDLE, S_WAKE, S_SCAN, S_AIM, S_PICK, S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  priority_req;
		logic [31:0] ticks;
		logic [2:0]  queue_index;
		logic [7:0]  queue_nonempty_mask;
		logic [7:0]  queue_nonfull_mask;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic [3:0]  new_task_id;
		logic [3:0]  running_task;
		logic [3:0]  prior_task;
		logic        switched;
		logic        user_task_running;
		logic [31:0] now_ticks;
	} out_item_t;

	// Control handed from the sequencer into the row of task cells.
	typedef struct packed {
		logic create;
		logic block_delay;
		logic block_ne;
		logic block_nf;
		logic wake;
		logic release_run;
		logic set_run;
	} cell_ctl_t;
endpackage
`default_nettype wire

@@ sv/priority_round_robin_task_scheduler_top.sv @@
`default_nettype none
// Hardware task scheduler. A command beat is taken at a rising edge where start is high
// and busy is low; busy then stays high until the single result beat has been shown on
// done for one cycle. The receiver cannot stall, so out_item must be sampled whenever
// done is high. Create, start and refused commands go from S_WAKE straight to S_DONE.
// Tick, yield, delay and wait block the caller in S_WAKE, wake tasks in S_SCAN, pick
// the target level in S_AIM, then in S_PICK step the round-robin pointer over entries
// (up to that level's member count, at most MAX_TASKS) and commit the choice before
// showing their result in S_DONE. busy falls in the cycle after done, when the next
// command can be taken.
module priority_round_robin_task_scheduler_top #(
	parameter int MAX_TASKS  = prts_pkg::MAX_TASKS_D,
	parameter int NUM_LEVELS = prts_pkg::NUM_LEVELS_D,
	parameter int NUM_QUEUES = prts_pkg::NUM_QUEUES_D,
	parameter int TIME_BITS  = prts_pkg::TIME_BITS_D
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire prts_pkg::in_item_t   in_item,
	output logic                      done,
	output prts_pkg::out_item_t       out_item
);
	import prts_pkg::*;

	localparam int SLOT_W = $clog2(MAX_TASKS + 1);
	localparam int LVL_W  = $clog2(NUM_LEVELS + 1);
	localparam int LIX_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int PTR_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int QW     = 3;

	state_t st_q, st_d;
	in_item_t it_q;
	cell_ctl_t ctl;

	logic [TIME_BITS-1:0] now_q;
	logic                 started_q;
	logic [CNT_W-1:0]     made_q;
	logic [SLOT_W-1:0]    cur_q, last_q;
	logic [CNT_W-1:0]     cnt_q [NUM_LEVELS];
	logic [PTR_W-1:0]     ptr_q [NUM_LEVELS];
	logic                 ptr_b4_q [NUM_LEVELS];
	logic [SLOT_W-1:0]    mem_q [NUM_LEVELS][MAX_TASKS];
	logic [LVL_W-1:0]     tgt_q;
	logic [PTR_W-1:0]     p_q;
	logic [CNT_W-1:0]     j_q;
	logic [SLOT_W-1:0]    chosen_q;
	logic                 found_q;
	logic                 acc_q, sw_q;
	logic [SLOT_W-1:0]    newid_q;

	logic [MAX_TASKS-1:0] rdy;
	logic [LVL_W-1:0]     lvl [MAX_TASKS];
	logic [MAX_TASKS-1:0] sel, run_sel;
	logic [LVL_W-1:0]     lvl_clamp;
	logic [LIX_W-1:0]     lvl_ix, tgt_ix;
	logic [TIME_BITS-1:0] len, wake_t;
	logic                 user_cur, ok;
	cmd_t                 cmd;

	assign cmd = cmd_t'(it_q.cmd);
	assign len = TIME_BITS'(it_q.ticks);
	assign wake_t = now_q + len;
	assign user_cur = (cur_q != SLOT_W'(MAX_TASKS));
	assign lvl_clamp = (32'(it_q.priority_req) > NUM_LEVELS - 1) ?
		LVL_W'(NUM_LEVELS - 1) : LVL_W'(it_q.priority_req);
	assign lvl_ix = lvl_clamp[LIX_W-1:0];
	assign tgt_ix = tgt_q[LIX_W-1:0];

	// Command acceptance rules.
	always_comb begin
		case (cmd)
			CMD_CREATE: ok = (32'(made_q) < MAX_TASKS);
			CMD_START:  ok = !started_q;
			CMD_TICK, CMD_YIELD: ok = started_q;
			CMD_DELAY:  ok = started_q && user_cur && (len != '0);
			CMD_WAIT_NE, CMD_WAIT_NF:
				ok = started_q && user_cur && (32'(it_q.queue_index) < NUM_QUEUES);
			default:    ok = 1'b0;
		endcase
	end

	// The row of task cells.
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		assign sel[i] = (cmd == CMD_CREATE) ? (32'(made_q) == i) : (32'(cur_q) == i);
		assign run_sel[i] = found_q && (32'(chosen_q) == i);
		prts_cell #(.TIME_BITS(TIME_BITS), .LVL_W(LVL_W), .QW(QW)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .sel(sel[i]), .run_sel(run_sel[i]),
			.lvl_in(lvl_clamp), .wake_in(wake_t), .q_in(it_q.queue_index), .now(now_q),
			.ne_mask(it_q.queue_nonempty_mask),
			.nf_mask(it_q.queue_nonfull_mask), .ready(rdy[i]), .level(lvl[i])
		);
	end

	// Highest ready level after wake.
	logic [LVL_W-1:0] best;
	logic [LIX_W-1:0] best_ix;
	always_comb begin
		best = LVL_W'(NUM_LEVELS);
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (32'(made_q) > i && rdy[i] && lvl[i] < best) best = lvl[i];
		end
	end
	assign best_ix = best[LIX_W-1:0];

	// Pointer start for the chosen level; before the first entry it sits on the last one.
	logic [PTR_W-1:0] p_start;
	always_comb begin
		p_start = '0;
		if (32'(best) < NUM_LEVELS) begin
			if (ptr_b4_q[best_ix]) p_start = PTR_W'(cnt_q[best_ix] - 1'b1);
			else p_start = ptr_q[best_ix];
		end
	end

	// Candidate at the stepping pointer.
	logic [PTR_W-1:0] p_nx;
	logic [SLOT_W-1:0] cand;
	logic [CNT_W-1:0] tcnt;
	assign tcnt = (32'(tgt_q) < NUM_LEVELS) ? cnt_q[tgt_ix] : '0;
	assign p_nx = (32'(p_q) + 1 >= 32'(tcnt)) ? '0 : p_q + 1'b1;
	assign cand = mem_q[tgt_ix][p_nx];

	// Sequencer.
	always_comb begin
		st_d = st_q;
		ctl = '0;
		busy = (st_q != S_IDLE);
		unique case (st_q)
			S_IDLE: if (start) st_d = S_WAKE;
			S_WAKE: begin
				if (ok && (cmd == CMD_CREATE)) begin
					ctl.create = 1'b1; st_d = S_DONE;
				end else if (ok && cmd != CMD_START) begin
					ctl.block_delay = (cmd == CMD_DELAY);
					ctl.block_ne = (cmd == CMD_WAIT_NE);
					ctl.block_nf = (cmd == CMD_WAIT_NF);
					ctl.release_run = 1'b1;
					st_d = S_SCAN;
				end else st_d = S_DONE;
			end
			S_SCAN: begin
				ctl.wake = 1'b1; st_d = S_AIM;
			end
			S_AIM: st_d = S_PICK;
			S_PICK: begin
				if (found_q || j_q >= tcnt) begin
					ctl.set_run = 1'b1; st_d = S_DONE;
				end
			end
			S_DONE: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end

	// Level member table, appended on create.
	always_ff @(posedge clk) begin
		if (st_q == S_WAKE && ok && cmd == CMD_CREATE)
			mem_q[lvl_ix][cnt_q[lvl_ix][PTR_W-1:0]] <= SLOT_W'(made_q);
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
			now_q <= '0; started_q <= 1'b0; made_q <= '0;
			cur_q <= SLOT_W'(MAX_TASKS); last_q <= SLOT_W'(MAX_TASKS);
			acc_q <= 1'b0; sw_q <= 1'b0; newid_q <= '0; found_q <= 1'b0;
			tgt_q <= '0; p_q <= '0; j_q <= '0; chosen_q <= '0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				cnt_q[l] <= '0; ptr_q[l] <= '0; ptr_b4_q[l] <= 1'b1;
			end
		end else begin
			unique case (st_q)
				S_IDLE: if (start) it_q <= in_item;
				S_WAKE: begin
					acc_q <= ok; newid_q <= '0;
					sw_q <= ok && cmd != CMD_CREATE && cmd != CMD_START;
					if (ok && cmd == CMD_CREATE) begin
						newid_q <= SLOT_W'(made_q);
						made_q <= made_q + 1'b1;
						cnt_q[lvl_ix] <= cnt_q[lvl_ix] + 1'b1;
					end
					if (ok && cmd == CMD_START) started_q <= 1'b1;
					if (ok && cmd == CMD_TICK) now_q <= now_q + 1'b1;
				end
				S_SCAN: ;
				// Target level and pointer start are taken once the wake has settled.
				S_AIM: begin
					tgt_q <= best; p_q <= p_start;
					found_q <= 1'b0; j_q <= '0;
				end
				S_PICK: begin
					if (!found_q && j_q < tcnt) begin
						p_q <= p_nx; j_q <= j_q + 1'b1;
						if (rdy[cand[PTR_W-1:0]]) begin
							found_q <= 1'b1; chosen_q <= cand;
						end
					end else begin
						if (32'(tgt_q) < NUM_LEVELS) begin
							ptr_q[tgt_ix] <= p_q;
							if (tcnt != '0) ptr_b4_q[tgt_ix] <= 1'b0;
						end
						last_q <= cur_q;
						cur_q <= found_q ? chosen_q : SLOT_W'(MAX_TASKS);
					end
				end
				S_DONE: found_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// Result beat.
	assign done = (st_q == S_DONE);
	always_comb begin
		out_item = '0;
		out_item.accepted = acc_q;
		out_item.new_task_id = 4'(newid_q);
		out_item.running_task = 4'(cur_q);
		out_item.prior_task = 4'(last_q);
		out_item.switched = sw_q;
		out_item.user_task_running = started_q && user_cur;
		out_item.now_ticks = 32'(now_q);
	end
endmodule
`default_nettype wire

@@ sv/prts_cell.sv @@
`default_nettype none
// One task slot. Holds its status, level, wake time and wait condition.
module prts_cell #(
	parameter int TIME_BITS = 32,
	parameter int LVL_W = 2,
	parameter int QW = 3
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire prts_pkg::cell_ctl_t    ctl,
	input  wire                         sel,       // this slot is addressed
	input  wire                         run_sel,   // this slot is chosen
	input  wire  [LVL_W-1:0]            lvl_in,
	input  wire  [TIME_BITS-1:0]        wake_in,
	input  wire  [QW-1:0]               q_in,
	input  wire  [TIME_BITS-1:0]        now,
	input  wire  [(1<<QW)-1:0]          ne_mask,
	input  wire  [(1<<QW)-1:0]          nf_mask,
	output logic                        ready,
	output logic [LVL_W-1:0]            level
);
	import prts_pkg::*;

	status_t              st_q;
	wait_t                wk_q;
	logic                 arm_q;
	logic [TIME_BITS-1:0] wt_q;
	logic [QW-1:0]        wq_q;
	logic [LVL_W-1:0]     lvl_q;
	logic                 hit_ne, hit_nf, hit_t;

	assign hit_ne = ne_mask[wq_q];
	assign hit_nf = nf_mask[wq_q];
	assign hit_t  = arm_q && (wt_q == now);
	assign ready  = (st_q == ST_READY);
	assign level  = lvl_q;

	// Per-slot status update. The sequencer issues at most one of these per cycle,
	// except that blocking the addressed slot and releasing the running one coincide.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_READY;
			wk_q  <= WAIT_NONE;
			arm_q <= 1'b0;
			wt_q  <= '0;
			wq_q  <= '0;
			lvl_q <= '0;
		end else begin
			if (ctl.create && sel) begin
				st_q <= ST_READY; wk_q <= WAIT_NONE; arm_q <= 1'b0;
				wt_q <= '0; wq_q <= '0; lvl_q <= lvl_in;
			end else if (ctl.block_delay && sel) begin
				st_q <= ST_BLOCKED; arm_q <= 1'b1; wt_q <= wake_in;
			end else if ((ctl.block_ne || ctl.block_nf) && sel) begin
				st_q <= ST_BLOCKED; wq_q <= q_in;
				wk_q <= ctl.block_ne ? WAIT_NONEMPTY : WAIT_NONFULL;
			end else if (ctl.release_run && st_q == ST_RUNNING) begin
				st_q <= ST_READY;
			end else if (ctl.wake && st_q == ST_BLOCKED) begin
				if (hit_t) begin
					arm_q <= 1'b0; st_q <= ST_READY;
				end else if (wk_q == WAIT_NONEMPTY && hit_ne) begin
					wk_q <= WAIT_NONE; st_q <= ST_READY;
				end else if (wk_q == WAIT_NONFULL && hit_nf) begin
					wk_q <= WAIT_NONE; st_q <= ST_READY;
				end
			end else if (ctl.set_run && run_sel) begin
				st_q <= ST_RUNNING;
			end
		end
	end
endmodule
`default_nettype wire

@@ verif/tb_priority_round_robin_task_scheduler_top.sv @@
`default_nettype none
module tb_priority_round_robin_task_scheduler_top;
	timeunit 1ns;
	timeprecision 1ps;
	import prts_pkg::*;

	localparam int NTASK = MAX_TASKS_D;
	localparam int NLVL = NUM_LEVELS_D;
	localparam int IDLE = NTASK;

	// Scoreboard: holds the scheduler's predicted state and the results still owed.
	class sched_scoreboard;
		status_t status[NTASK+1];
		logic [31:0] wake_at[NTASK+1];
		bit armed[NTASK+1];
		wait_t wkind[NTASK+1];
		logic [2:0] wq[NTASK+1];
		int members[NLVL+1][NTASK];
		int lcount[NLVL+1];
		int lptr[NLVL+1];
		int cur_slot, last_slot, made;
		logic [31:0] now;
		bit running;
		out_item_t owed[$];
		int errors;

		function void clear();
			for (int i = 0; i <= NTASK; i++) begin
				status[i] = ST_READY;
				wake_at[i] = '0;
				armed[i] = 0;
				wkind[i] = WAIT_NONE;
				wq[i] = '0;
			end
			for (int i = 0; i <= NLVL; i++) begin
				lcount[i] = 0;
				lptr[i] = -1;
			end
			cur_slot = IDLE;
			last_slot = IDLE;
			made = 0;
			now = '0;
			running = 0;
			owed.delete();
			errors = 0;
		endfunction

		function void wake_one(int s, logic [7:0] ne, logic [7:0] nf);
			if (status[s] != ST_BLOCKED)
				return;
			if (armed[s] && wake_at[s] == now) begin
				armed[s] = 0;
				status[s] = ST_READY;
			end
			if (status[s] == ST_BLOCKED && wkind[s] == WAIT_NONEMPTY && ne[wq[s]]) begin
				wkind[s] = WAIT_NONE;
				status[s] = ST_READY;
			end
			if (status[s] == ST_BLOCKED && wkind[s] == WAIT_NONFULL && nf[wq[s]]) begin
				wkind[s] = WAIT_NONE;
				status[s] = ST_READY;
			end
		endfunction

		function void reschedule(logic [7:0] ne, logic [7:0] nf);
			int target, p, pick, s;
			target = NLVL;
			if (status[cur_slot] == ST_RUNNING)
				status[cur_slot] = ST_READY;
			for (int lv = 0; lv < NLVL; lv++)
				for (int j = 0; j < lcount[lv]; j++) begin
					s = members[lv][j];
					wake_one(s, ne, nf);
					if (status[s] == ST_READY && lv < target)
						target = lv;
				end
			pick = IDLE;
			p = lptr[target];
			for (int j = 0; j < lcount[target]; j++) begin
				p = p + 1;
				if (p >= lcount[target])
					p = 0;
				if (status[members[target][p]] == ST_READY) begin
					pick = members[target][p];
					break;
				end
			end
			lptr[target] = p;
			last_slot = cur_slot;
			cur_slot = pick;
			status[pick] = ST_RUNNING;
		endfunction

		// Note an accepted input beat and queue its expected result.
		function void note_input(in_item_t it);
			out_item_t r;
			bit acc, sw, user_cur;
			int newid, lv;
			acc = 0;
			sw = 0;
			newid = 0;
			user_cur = cur_slot != IDLE;
			case (cmd_t'(it.cmd))
				CMD_CREATE: if (made < NTASK) begin
					lv = (it.priority_req > NLVL - 1) ? NLVL - 1 : it.priority_req;
					status[made] = ST_READY;
					wake_at[made] = '0;
					armed[made] = 0;
					wkind[made] = WAIT_NONE;
					wq[made] = '0;
					members[lv][lcount[lv]] = made;
					lcount[lv]++;
					newid = made;
					made++;
					acc = 1;
				end
				CMD_START: if (!running) begin
					status[IDLE] = ST_READY;
					members[NLVL][0] = IDLE;
					lcount[NLVL] = 1;
					running = 1;
					acc = 1;
				end
				CMD_TICK: if (running) begin
					now = now + 1;
					reschedule(it.queue_nonempty_mask, it.queue_nonfull_mask);
					acc = 1;
				end
				CMD_YIELD: if (running) begin
					reschedule(it.queue_nonempty_mask, it.queue_nonfull_mask);
					acc = 1;
				end
				CMD_DELAY: if (running && user_cur && it.ticks != 0) begin
					status[cur_slot] = ST_BLOCKED;
					wake_at[cur_slot] = now + it.ticks;
					armed[cur_slot] = 1;
					reschedule(it.queue_nonempty_mask, it.queue_nonfull_mask);
					acc = 1;
				end
				CMD_WAIT_NE, CMD_WAIT_NF: if (running && user_cur) begin
					status[cur_slot] = ST_BLOCKED;
					wkind[cur_slot] = (it.cmd == CMD_WAIT_NE) ? WAIT_NONEMPTY : WAIT_NONFULL;
					wq[cur_slot] = it.queue_index;
					reschedule(it.queue_nonempty_mask, it.queue_nonfull_mask);
					acc = 1;
				end
				default: ;
			endcase
			sw = acc && it.cmd != CMD_CREATE && it.cmd != CMD_START;
			r.accepted = acc;
			r.new_task_id = newid[3:0];
			r.running_task = cur_slot[3:0];
			r.prior_task = last_slot[3:0];
			r.switched = sw;
			r.user_task_running = running && cur_slot != IDLE;
			r.now_ticks = now;
			owed.push_back(r);
		endfunction

		// Compare one result beat with the oldest expectation.
		function void check_result(out_item_t got);
			out_item_t e;
			if (owed.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.accepted !== e.accepted) begin
				$error("accepted: expected %0d, got %0d", e.accepted, got.accepted);
				errors++;
			end
			if (got.new_task_id !== e.new_task_id) begin
				$error("new_task_id: expected %0d, got %0d", e.new_task_id, got.new_task_id);
				errors++;
			end
			if (got.running_task !== e.running_task) begin
				$error("running_task: expected %0d, got %0d", e.running_task, got.running_task);
				errors++;
			end
			if (got.prior_task !== e.prior_task) begin
				$error("prior_task: expected %0d, got %0d", e.prior_task, got.prior_task);
				errors++;
			end
			if (got.switched !== e.switched) begin
				$error("switched: expected %0d, got %0d", e.switched, got.switched);
				errors++;
			end
			if (got.user_task_running !== e.user_task_running) begin
				$error("user_task_running: expected %0d, got %0d",
					e.user_task_running, got.user_task_running);
				errors++;
			end
			if (got.now_ticks !== e.now_ticks) begin
				$error("now_ticks: expected %0d, got %0d", e.now_ticks, got.now_ticks);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic done;
	in_item_t in_item = '0;
	out_item_t out_item;
	sched_scoreboard sb;
	bit gaps_on = 1;

	priority_round_robin_task_scheduler_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_item(in_item), .done(done), .out_item(out_item)
	);

	always #6 clk = ~clk;

	// Result beats are taken at every rising edge where done is high.
	always @(posedge clk)
		if (arst_n && done)
			sb.check_result(out_item);

	// Present one command and hold it until the block takes it.
	task automatic issue(in_item_t it);
		int gap;
		if (gaps_on && $urandom_range(3) == 0) begin
			gap = $urandom_range(15, 1);
			@(negedge clk);
			start <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_item <= it;
		start <= 1;
		forever begin
			@(posedge clk);
			if (!busy) begin
				sb.note_input(it);
				break;
			end
		end
	endtask

	function automatic in_item_t make_cmd(cmd_t c, logic [3:0] pr, logic [31:0] t,
		logic [2:0] q, logic [7:0] ne, logic [7:0] nf);
		in_item_t it;
		it.cmd = c;
		it.priority_req = pr;
		it.ticks = t;
		it.queue_index = q;
		it.queue_nonempty_mask = ne;
		it.queue_nonfull_mask = nf;
		return it;
	endfunction

	// Random beat: mostly scheduling traffic, short delays, sparse queue masks.
	function automatic in_item_t rand_cmd();
		in_item_t it;
		int k;
		it = '0;
		k = $urandom_range(99);
		if (k < 3) it.cmd = CMD_CREATE;
		else if (k < 5) it.cmd = CMD_START;
		else if (k < 40) it.cmd = CMD_TICK;
		else if (k < 55) it.cmd = CMD_YIELD;
		else if (k < 72) it.cmd = CMD_DELAY;
		else if (k < 84) it.cmd = CMD_WAIT_NE;
		else if (k < 96) it.cmd = CMD_WAIT_NF;
		else it.cmd = CMD_UNUSED;
		it.priority_req = $urandom_range(15);
		k = $urandom_range(9);
		if (k == 0) it.ticks = $urandom();
		else if (k == 1) it.ticks = 0;
		else it.ticks = $urandom_range(6, 1);
		it.queue_index = $urandom_range(7);
		it.queue_nonempty_mask = ($urandom_range(3) == 0) ? $urandom_range(255) : 8'h00;
		it.queue_nonfull_mask = ($urandom_range(3) == 0) ? $urandom_range(255) : 8'h00;
		return it;
	endfunction

	task automatic drain();
		@(negedge clk);
		start <= 0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (3 + NTASK + 4) @(posedge clk);
	endtask

	initial begin
		sb = new();
		sb.clear();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: refusals before start, clamping, full table, special cases.
		issue(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_DELAY, 0, 5, 0, 0, 0));
		issue(make_cmd(CMD_UNUSED, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_CREATE, 4'hF, 32'hFFFF_FFFF, 3'h7, 8'hFF, 8'hFF));
		issue(make_cmd(CMD_CREATE, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_CREATE, 1, 0, 0, 0, 0));
		issue(make_cmd(CMD_YIELD, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_START, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_START, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_CREATE, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_YIELD, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_DELAY, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_DELAY, 0, 32'hFFFF_FFFF, 0, 0, 0));
		issue(make_cmd(CMD_WAIT_NE, 0, 0, 3'h7, 8'h80, 8'h00));
		issue(make_cmd(CMD_WAIT_NF, 0, 0, 3'h2, 8'h00, 8'h00));
		issue(make_cmd(CMD_TICK, 0, 0, 0, 8'h00, 8'h04));
		issue(make_cmd(CMD_CREATE, 2, 0, 0, 0, 0));
		issue(make_cmd(CMD_CREATE, 3, 0, 0, 0, 0));
		issue(make_cmd(CMD_CREATE, 1, 0, 0, 0, 0));
		issue(make_cmd(CMD_CREATE, 2, 0, 0, 0, 0));
		issue(make_cmd(CMD_CREATE, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_CREATE, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
		drain();

		// Random traffic; one pause for all results midway, no gaps at the end.
		for (int n = 0; n < 1500; n++) begin
			if (n == 700)
				drain();
			if (n == 1300)
				gaps_on = 0;
			issue(rand_cmd());
		end
		drain();

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
